// ----- design/mpq_pkg.sv -----
`timescale 1ns / 1ps

package mpq_pkg;

  // Store size and derived widths
  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Field widths of the item channels
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 5;

  // Operation codes carried in func
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } mpq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_RESULT
  } mpq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // take the offered item
    logic scan_en;   // step the minimum scan
    logic move;      // refill the freed slot, drop the count
    logic load_out;  // load the result into the output register
  } mpq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan; // offered item is a remove on a non-empty store
    logic scan_done; // every live entry has been read; the last one is compared this cycle
    logic out_free;  // output register can take a result this cycle
  } mpq_sts_t;

endpackage

// ----- design/mpq_in_if.sv -----
`timescale 1ns / 1ps

interface mpq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic signed [mpq_pkg::VALUE_W-1:0]   value_in;

  modport source (output valid, output func, output value_in, input ready);
  modport sink   (input valid, input func, input value_in, output ready);
endinterface

// ----- design/mpq_out_if.sv -----
`timescale 1ns / 1ps

interface mpq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mpq_pkg::STATUS_W-1:0]         status;
  logic signed [mpq_pkg::VALUE_W-1:0]   value_out;
  logic [mpq_pkg::LIVE_W-1:0]           live_count;

  modport source (output valid, output status, output value_out, output live_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input live_count,
                  output ready);
endinterface

// ----- design/mpq_datapath.sv -----
`timescale 1ns / 1ps

module mpq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mpq_pkg::mpq_cmd_t                   cmd,
  output mpq_pkg::mpq_sts_t                   sts,
  input  logic                                in_func,
  input  logic signed [mpq_pkg::VALUE_W-1:0]  in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [mpq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [mpq_pkg::VALUE_W-1:0]  out_value,
  output logic [mpq_pkg::LIVE_W-1:0]          out_live_count
);

  logic signed [mpq_pkg::VALUE_W-1:0] mem [mpq_pkg::DEPTH];
  logic signed [mpq_pkg::VALUE_W-1:0] rd_data_r;

  logic [mpq_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [mpq_pkg::CNT_W-1:0]          scan_r, scan_nxt;
  logic [mpq_pkg::CNT_W-1:0]          scan_prev;
  logic signed [mpq_pkg::VALUE_W-1:0] best_r;
  logic [mpq_pkg::IDX_W-1:0]          best_pos_r;

  mpq_pkg::mpq_status_t               res_status_r;
  logic signed [mpq_pkg::VALUE_W-1:0] res_value_r;

  logic                               out_valid_r;
  mpq_pkg::mpq_status_t               out_status_r;
  logic signed [mpq_pkg::VALUE_W-1:0] out_value_r;
  logic [mpq_pkg::LIVE_W-1:0]         out_live_r;

  logic                               full, empty;
  logic                               scan_done;
  logic                               rd_en, cmp_en, take;
  logic                               ins_ok;
  logic                               we;
  logic [mpq_pkg::IDX_W-1:0]          wa;
  logic signed [mpq_pkg::VALUE_W-1:0] wd;

  assign full      = (count_r == mpq_pkg::CNT_W'(mpq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign scan_done = (scan_r == count_r);

  // Read one entry a cycle; compare each entry in the cycle after its read
  assign rd_en     = cmd.scan_en && !scan_done;
  assign cmp_en    = cmd.scan_en && (scan_r != '0);
  assign scan_prev = scan_r - mpq_pkg::CNT_W'(1);
  assign take      = cmp_en && ((scan_r == mpq_pkg::CNT_W'(1)) || (rd_data_r < best_r));
  assign scan_nxt  = cmd.accept ? '0 : (rd_en ? scan_r + mpq_pkg::CNT_W'(1) : scan_r);

  assign ins_ok = cmd.accept && (in_func == mpq_pkg::FUNC_INSERT) && !full;
  assign we     = ins_ok || cmd.move;
  // On a move the last live entry was the final read, so it still sits in rd_data_r
  assign wa     = cmd.move ? best_pos_r : count_r[mpq_pkg::IDX_W-1:0];
  assign wd     = cmd.move ? rd_data_r : in_value;

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + mpq_pkg::CNT_W'(1);
    end else if (cmd.move) begin
      count_nxt = count_r - mpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_r[mpq_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r     <= rd_data_r;
      best_pos_r <= scan_prev[mpq_pkg::IDX_W-1:0];
    end
    if (cmd.accept) begin
      res_value_r <= '0;
      if (in_func == mpq_pkg::FUNC_INSERT) begin
        res_status_r <= full ? mpq_pkg::ST_OVERFLOW : mpq_pkg::ST_OK;
      end else begin
        res_status_r <= empty ? mpq_pkg::ST_UNDERFLOW : mpq_pkg::ST_OK;
      end
    end else if (cmd.move) begin
      res_value_r <= best_r;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_live_r   <= mpq_pkg::LIVE_W'(count_r);
    end
  end

  assign sts.need_scan = (in_func == mpq_pkg::FUNC_REMOVE) && !empty;
  assign sts.scan_done = scan_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value      = out_value_r;
  assign out_live_count = out_live_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH))
    else $error("live count beyond store depth");

  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |-> !empty && scan_done)
    else $error("slot refill without a finished scan");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == $past(count_r) + mpq_pkg::CNT_W'(1))
    else $error("insert did not advance the count");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken item");

endmodule

// ----- design/mpq_controller.sv -----
`timescale 1ns / 1ps

module mpq_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mpq_pkg::mpq_sts_t sts,
  output mpq_pkg::mpq_cmd_t cmd
);

  mpq_pkg::mpq_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_scan ? mpq_pkg::S_SCAN : mpq_pkg::S_RESULT;
        end
      end
      mpq_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = mpq_pkg::S_MOVE;
        end
      end
      mpq_pkg::S_MOVE: begin
        state_nxt = mpq_pkg::S_RESULT;
      end
      mpq_pkg::S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = mpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.scan_en  = 1'b0;
    cmd.move     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      mpq_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mpq_pkg::S_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      mpq_pkg::S_MOVE: begin
        cmd.move = 1'b1;
      end
      mpq_pkg::S_RESULT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpq_pkg::S_SCAN) && sts.scan_done |=> state_r == mpq_pkg::S_MOVE)
    else $error("scan finished but no refill followed");

endmodule

// ----- design/min_priority_queue.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in_if     in   valid/ready        func, value_in
// out_if    out  valid/ready        status, value_out, live_count
//
// Insert, overflow and underflow items go from accept to the result load. A remove
// over live entries passes accept, a scan in which the single store read port feeds one
// comparator one entry behind, a refill of the freed slot, then the result load.
// Reset (rst_n low, synchronous) empties the queue; store contents stay undefined.
// A result still waiting at the output holds the next item in its load cycle; no new
// item is taken until that load.

module min_priority_queue (
  input  logic         clk,
  input  logic         rst_n,
  mpq_in_if.sink       in_if,
  mpq_out_if.source    out_if
);

  mpq_pkg::mpq_cmd_t cmd;
  mpq_pkg::mpq_sts_t sts;

  // Sequencer: accept, scan, refill, hand the result over
  mpq_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, count, minimum tracker and output register
  mpq_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_if.func),
    .in_value       (in_if.value_in),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_status     (out_if.status),
    .out_value      (out_if.value_out),
    .out_live_count (out_if.live_count)
  );

endmodule
